// File: rtl/core/dwexpr_pkg.sv
// dwexpr_pkg: opcodes, status codes and shared types of the expression evaluator
// used by dwexpr_front, dwexpr_queue, dwexpr_back and the top level
package dwexpr_pkg;

   localparam logic [7:0] OP_ADDR    = 8'h03;
   localparam logic [7:0] OP_CONST1U = 8'h08;
   localparam logic [7:0] OP_CONST1S = 8'h09;
   localparam logic [7:0] OP_CONST2U = 8'h0a;
   localparam logic [7:0] OP_CONST2S = 8'h0b;
   localparam logic [7:0] OP_CONST4U = 8'h0c;
   localparam logic [7:0] OP_CONST4S = 8'h0d;
   localparam logic [7:0] OP_CONST8U = 8'h0e;
   localparam logic [7:0] OP_CONST8S = 8'h0f;
   localparam logic [7:0] OP_CONSTU  = 8'h10;
   localparam logic [7:0] OP_CONSTS  = 8'h11;
   localparam logic [7:0] OP_DUP     = 8'h12;
   localparam logic [7:0] OP_MINUS   = 8'h1c;
   localparam logic [7:0] OP_PLUS    = 8'h22;
   localparam logic [7:0] OP_LIT0    = 8'h30;
   localparam logic [7:0] OP_LIT31   = 8'h4f;

   localparam logic [3:0] ADDR_SIZE_RESET = 4'd8;
   localparam int unsigned QUEUE_DEPTH = 4;

   typedef enum logic [2:0] {
      ST_OK    = 3'd0,
      ST_UNSUP = 3'd1,
      ST_UNDER = 3'd2,
      ST_OVER  = 3'd3,
      ST_TRUNC = 3'd4,
      ST_EMPTY = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      PH_OPCODE = 2'd0,
      PH_FIXED  = 2'd1,
      PH_ULEB   = 2'd2,
      PH_SLEB   = 2'd3
   } phase_type;

   typedef enum logic [2:0] {
      CMD_NONE  = 3'd0,
      CMD_PUSH  = 3'd1,
      CMD_DUP   = 3'd2,
      CMD_ADD   = 3'd3,
      CMD_SUB   = 3'd4,
      CMD_UNSUP = 3'd5,
      CMD_TRUNC = 3'd6
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [63:0]  value;
      logic         last;
   } cmd_type;

endpackage

// File: rtl/core/dwarf_expression_stack_evaluator.sv
// dwarf_expression_stack_evaluator: top level of the location expression evaluator
// instantiates dwexpr_front, dwexpr_queue and dwexpr_back; depends on dwexpr_pkg
//
// Takes one expression byte per cycle on the req_ stream, with no gaps needed between
// bytes or expressions. The front decodes each byte in the cycle it is taken and posts
// one command into a four-entry queue; the back runs one command per cycle on the top
// two stack entries held in registers, spilling deeper entries to a STACK_DEPTH x 64
// memory whose read port is prefetched. The back registers a result on rsp_ for each
// byte marked tlast; a stalled result holds only the back, while the front keeps
// taking bytes until the queue fills. The stack needs no clearing after reset.
// csr_wr_data sets the address size (4 selects 4-byte addresses, any other value
// 8-byte) and must be written only while the block is idle; the block does not check.
module dwarf_expression_stack_evaluator #(
   parameter int unsigned STACK_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [3:0]  csr_wr_data,  // addr_size
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // code_byte
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,    // result_value
   output logic [2:0]  rsp_tuser     // status
);

   dwexpr_pkg::cmd_type front_cmd;
   dwexpr_pkg::cmd_type back_cmd;
   logic                front_valid;
   logic                front_ready;
   logic                back_valid;
   logic                back_ready;

   dwexpr_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .cmd_valid   (front_valid),
      .cmd_ready   (front_ready),
      .cmd         (front_cmd)
   );

   dwexpr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_cmd    (front_cmd),
      .out_valid (back_valid),
      .out_ready (back_ready),
      .out_cmd   (back_cmd)
   );

   dwexpr_back #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (back_valid),
      .cmd_ready  (back_ready),
      .cmd        (back_cmd),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser <= dwexpr_pkg::ST_EMPTY)
      else $error("status code out of range");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != dwexpr_pkg::ST_OK |-> rsp_tdata == 64'd0)
      else $error("nonzero value with error status");

   a_result_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(back_valid && back_ready && back_cmd.last))
      else $error("result without a last command");

endmodule

// File: rtl/core/dwexpr_front.sv
// dwexpr_front: byte decoder and operand assembler, one byte per cycle while the queue has room
// turns expression bytes into stack commands; depends on dwexpr_pkg
module dwexpr_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [3:0]          csr_wr_data,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [7:0]          req_tdata,
   input  logic                req_tlast,
   output logic                cmd_valid,
   input  logic                cmd_ready,
   output dwexpr_pkg::cmd_type cmd
);

   logic [3:0]            addr_size_ff;
   dwexpr_pkg::phase_type phase_ff, phase_in;
   logic                  err_ff, err_in;
   logic [3:0]            left_ff, left_in;
   logic [3:0]            len_ff, len_in;
   logic                  sgn_ff, sgn_in;
   logic [2:0]            idx_ff, idx_in;
   logic [63:0]           accum_ff, accum_in;
   logic [6:0]            shift_ff, shift_in;
   logic [63:0]           fixed_val;
   logic [63:0]           leb_val;
   logic                  accept;

   assign accept     = req_tvalid && cmd_ready;
   assign req_tready = cmd_ready;
   assign cmd_valid  = req_tvalid;

   always_comb begin
      phase_in  = phase_ff;
      err_in    = err_ff;
      left_in   = left_ff;
      len_in    = len_ff;
      sgn_in    = sgn_ff;
      idx_in    = idx_ff;
      accum_in  = accum_ff;
      shift_in  = shift_ff;
      cmd.kind  = dwexpr_pkg::CMD_NONE;
      cmd.value = 64'd0;
      cmd.last  = req_tlast;
      fixed_val = 64'd0;
      leb_val   = 64'd0;
      if (!err_ff) begin
         case (phase_ff)
            dwexpr_pkg::PH_OPCODE: begin
               accum_in = 64'd0;
               shift_in = 7'd0;
               idx_in   = 3'd0;
               sgn_in   = 1'b0;
               case (req_tdata)
                  dwexpr_pkg::OP_ADDR: begin
                     phase_in = dwexpr_pkg::PH_FIXED;
                     len_in   = (addr_size_ff == 4'd4) ? 4'd4 : 4'd8;
                  end
                  dwexpr_pkg::OP_CONST1U, dwexpr_pkg::OP_CONST1S: begin
                     phase_in = dwexpr_pkg::PH_FIXED;
                     len_in   = 4'd1;
                     sgn_in   = (req_tdata == dwexpr_pkg::OP_CONST1S);
                  end
                  dwexpr_pkg::OP_CONST2U, dwexpr_pkg::OP_CONST2S: begin
                     phase_in = dwexpr_pkg::PH_FIXED;
                     len_in   = 4'd2;
                     sgn_in   = (req_tdata == dwexpr_pkg::OP_CONST2S);
                  end
                  dwexpr_pkg::OP_CONST4U, dwexpr_pkg::OP_CONST4S: begin
                     phase_in = dwexpr_pkg::PH_FIXED;
                     len_in   = 4'd4;
                     sgn_in   = (req_tdata == dwexpr_pkg::OP_CONST4S);
                  end
                  dwexpr_pkg::OP_CONST8U, dwexpr_pkg::OP_CONST8S: begin
                     phase_in = dwexpr_pkg::PH_FIXED;
                     len_in   = 4'd8;
                  end
                  dwexpr_pkg::OP_CONSTU: begin
                     phase_in = dwexpr_pkg::PH_ULEB;
                  end
                  dwexpr_pkg::OP_CONSTS: begin
                     phase_in = dwexpr_pkg::PH_SLEB;
                  end
                  dwexpr_pkg::OP_DUP: begin
                     cmd.kind = dwexpr_pkg::CMD_DUP;
                  end
                  dwexpr_pkg::OP_PLUS: begin
                     cmd.kind = dwexpr_pkg::CMD_ADD;
                  end
                  dwexpr_pkg::OP_MINUS: begin
                     cmd.kind = dwexpr_pkg::CMD_SUB;
                  end
                  default: begin
                     if (req_tdata inside {[dwexpr_pkg::OP_LIT0:dwexpr_pkg::OP_LIT31]}) begin
                        cmd.kind  = dwexpr_pkg::CMD_PUSH;
                        cmd.value = {56'd0, req_tdata - dwexpr_pkg::OP_LIT0};
                     end else begin
                        cmd.kind = dwexpr_pkg::CMD_UNSUP;
                        err_in   = 1'b1;
                     end
                  end
               endcase
               left_in = len_in;
            end
            dwexpr_pkg::PH_FIXED: begin
               accum_in = accum_ff | ({56'd0, req_tdata} << {idx_ff, 3'b000});
               idx_in   = idx_ff + 3'd1;
               left_in  = left_ff - 4'd1;
               fixed_val = accum_in;
               if (sgn_ff) begin
                  case (len_ff)
                     4'd1:    fixed_val = {{56{accum_in[7]}}, accum_in[7:0]};
                     4'd2:    fixed_val = {{48{accum_in[15]}}, accum_in[15:0]};
                     4'd4:    fixed_val = {{32{accum_in[31]}}, accum_in[31:0]};
                     default: fixed_val = accum_in;
                  endcase
               end
               if (left_in == 4'd0) begin
                  cmd.kind  = dwexpr_pkg::CMD_PUSH;
                  cmd.value = fixed_val;
                  phase_in  = dwexpr_pkg::PH_OPCODE;
               end
            end
            default: begin
               if (shift_ff < 7'd64) begin
                  accum_in = accum_ff | ({57'd0, req_tdata[6:0]} << shift_ff[5:0]);
                  shift_in = shift_ff + 7'd7;
               end
               leb_val = accum_in;
               if (phase_ff == dwexpr_pkg::PH_SLEB && shift_in < 7'd64 && req_tdata[6]) begin
                  leb_val = accum_in | ({64{1'b1}} << shift_in[5:0]);
               end
               if (!req_tdata[7]) begin
                  cmd.kind  = dwexpr_pkg::CMD_PUSH;
                  cmd.value = leb_val;
                  phase_in  = dwexpr_pkg::PH_OPCODE;
               end
            end
         endcase
      end
      if (req_tlast) begin
         if (!err_ff && phase_in != dwexpr_pkg::PH_OPCODE) begin
            cmd.kind = dwexpr_pkg::CMD_TRUNC;
         end
         phase_in = dwexpr_pkg::PH_OPCODE;
         err_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_size_ff <= dwexpr_pkg::ADDR_SIZE_RESET;
         phase_ff     <= dwexpr_pkg::PH_OPCODE;
         err_ff       <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            addr_size_ff <= csr_wr_data;
         end
         if (accept) begin
            phase_ff <= phase_in;
            err_ff   <= err_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         left_ff  <= left_in;
         len_ff   <= len_in;
         sgn_ff   <= sgn_in;
         idx_ff   <= idx_in;
         accum_ff <= accum_in;
         shift_ff <= shift_in;
      end
   end

endmodule

// File: rtl/core/dwexpr_queue.sv
// dwexpr_queue: small command queue between decoder and stack unit
// depends on dwexpr_pkg
module dwexpr_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  dwexpr_pkg::cmd_type in_cmd,
   output logic                out_valid,
   input  logic                out_ready,
   output dwexpr_pkg::cmd_type out_cmd
);

   localparam int unsigned PW = $clog2(dwexpr_pkg::QUEUE_DEPTH);
   localparam int unsigned CW = $clog2(dwexpr_pkg::QUEUE_DEPTH + 1);

   dwexpr_pkg::cmd_type entry_ff [dwexpr_pkg::QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          push;
   logic          pop;

   assign in_ready  = (count_ff != CW'(dwexpr_pkg::QUEUE_DEPTH));
   assign out_valid = (count_ff != CW'(0));
   assign out_cmd   = entry_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PW'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PW'(1) : rd_ptr_ff;
      count_in  = count_ff + CW'(push) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_cmd;
      end
   end

endmodule

// File: rtl/core/dwexpr_back.sv
// dwexpr_back: stack unit with top two entries in registers and a spill memory
// executes one command per cycle unless a held result stalls it; depends on dwexpr_pkg
module dwexpr_back #(
   parameter int unsigned STACK_DEPTH = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                cmd_valid,
   output logic                cmd_ready,
   input  dwexpr_pkg::cmd_type cmd,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [63:0]         rsp_tdata,
   output logic [2:0]          rsp_tuser
);

   localparam int unsigned DW = $clog2(STACK_DEPTH + 1);
   localparam int unsigned AW = $clog2(STACK_DEPTH);

   logic [63:0]            stack_mem [STACK_DEPTH];
   logic [DW-1:0]          depth_ff, depth_in;
   dwexpr_pkg::status_type err_ff, err_in;
   logic [63:0]            tos_ff, tos_in;
   logic [63:0]            nos_ff, nos_in;
   logic [63:0]            below_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   dwexpr_pkg::status_type rsp_status_ff, rsp_status_in;
   logic [63:0]            rsp_value_ff, rsp_value_in;
   logic                   pop;
   logic                   wr_en;
   logic [AW-1:0]          wr_addr;
   logic [AW-1:0]          rd_addr;
   logic [63:0]            push_val;

   assign cmd_ready  = !rsp_valid_ff || rsp_tready;
   assign pop        = cmd_valid && cmd_ready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tuser  = rsp_status_ff;

   always_comb begin
      depth_in      = depth_ff;
      err_in        = err_ff;
      tos_in        = tos_ff;
      nos_in        = nos_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      wr_en         = 1'b0;
      wr_addr       = AW'(depth_ff - DW'(2));
      push_val      = (cmd.kind == dwexpr_pkg::CMD_DUP) ? tos_ff : cmd.value;
      if (pop) begin
         if (err_ff == dwexpr_pkg::ST_OK) begin
            case (cmd.kind)
               dwexpr_pkg::CMD_PUSH, dwexpr_pkg::CMD_DUP: begin
                  if (cmd.kind == dwexpr_pkg::CMD_DUP && depth_ff == DW'(0)) begin
                     err_in = dwexpr_pkg::ST_UNDER;
                  end else if (depth_ff == DW'(STACK_DEPTH)) begin
                     err_in = dwexpr_pkg::ST_OVER;
                  end else begin
                     wr_en    = (depth_ff >= DW'(2));
                     tos_in   = push_val;
                     nos_in   = tos_ff;
                     depth_in = depth_ff + DW'(1);
                  end
               end
               dwexpr_pkg::CMD_ADD, dwexpr_pkg::CMD_SUB: begin
                  if (depth_ff < DW'(2)) begin
                     err_in = dwexpr_pkg::ST_UNDER;
                  end else begin
                     tos_in   = (cmd.kind == dwexpr_pkg::CMD_ADD) ? nos_ff + tos_ff
                                                                  : nos_ff - tos_ff;
                     nos_in   = below_ff;
                     depth_in = depth_ff - DW'(1);
                  end
               end
               dwexpr_pkg::CMD_UNSUP: err_in = dwexpr_pkg::ST_UNSUP;
               dwexpr_pkg::CMD_TRUNC: err_in = dwexpr_pkg::ST_TRUNC;
               default: ;
            endcase
         end
         if (cmd.last) begin
            rsp_valid_in = 1'b1;
            if (err_in != dwexpr_pkg::ST_OK) begin
               rsp_status_in = err_in;
            end else if (depth_in == DW'(0)) begin
               rsp_status_in = dwexpr_pkg::ST_EMPTY;
            end else begin
               rsp_status_in = dwexpr_pkg::ST_OK;
            end
            rsp_value_in = (rsp_status_in == dwexpr_pkg::ST_OK) ? tos_in : 64'd0;
            depth_in     = DW'(0);
            err_in       = dwexpr_pkg::ST_OK;
         end
      end
      rd_addr = AW'(depth_in - DW'(3));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff     <= '0;
         err_ff       <= dwexpr_pkg::ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         depth_ff     <= depth_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tos_ff        <= tos_in;
      nos_ff        <= nos_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
   end

   // spill memory, read port bypasses a same-cycle write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         stack_mem[wr_addr] <= nos_ff;
      end
      if (wr_en && wr_addr == rd_addr) begin
         below_ff <= nos_ff;
      end else begin
         below_ff <= stack_mem[rd_addr];
      end
   end

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
// tb: self-checking bench for dwarf_expression_stack_evaluator
// byte stream in, status and value out; depends on dwexpr_pkg and the rtl of the evaluator
// checks every result against its own predictor, or a typed probe against its table value
module tb;

   localparam int unsigned STACK_DEPTH = 16;
   localparam int unsigned N_PROBES = 24;

   typedef struct {
      dwexpr_pkg::status_type status;
      logic [63:0]            value;
   } outcome_type;

   typedef struct {
      logic [7:0]             code;
      logic                   last;
      logic                   typed;
      dwexpr_pkg::status_type status;
      logic [63:0]            value;
   } probe_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [3:0]  csr_wr_data = 4'd0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;
   logic [2:0]  rsp_tuser;

   dwarf_expression_stack_evaluator #(.STACK_DEPTH(STACK_DEPTH)) dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // predictor state
   logic [63:0]            eval_stack [STACK_DEPTH];
   int unsigned            eval_depth;
   dwexpr_pkg::phase_type  eval_phase;
   logic [7:0]             eval_op;
   int unsigned            eval_left;
   logic [63:0]            eval_accum;
   int unsigned            eval_shift;
   dwexpr_pkg::status_type eval_error;
   logic [3:0]             addr_size;

   outcome_type pending_results [$];
   int unsigned mismatches = 0;
   int unsigned sent = 0;
   bit          quiet = 1'b0;
   int unsigned stall_left = 0;

   probe_type probes [N_PROBES] = '{
      '{dwexpr_pkg::OP_LIT0,    1'b1, 1'b1, dwexpr_pkg::ST_OK,    64'd0},
      '{dwexpr_pkg::OP_LIT31,   1'b1, 1'b1, dwexpr_pkg::ST_OK,    64'd31},
      '{8'hff,                  1'b1, 1'b1, dwexpr_pkg::ST_UNSUP, 64'd0},
      '{8'h00,                  1'b1, 1'b1, dwexpr_pkg::ST_UNSUP, 64'd0},
      '{dwexpr_pkg::OP_DUP,     1'b1, 1'b1, dwexpr_pkg::ST_UNDER, 64'd0},
      '{dwexpr_pkg::OP_LIT31,   1'b0, 1'b0, dwexpr_pkg::ST_OK,    64'd0},
      '{dwexpr_pkg::OP_PLUS,    1'b1, 1'b1, dwexpr_pkg::ST_UNDER, 64'd0},
      '{dwexpr_pkg::OP_CONST1U, 1'b0, 1'b0, dwexpr_pkg::ST_OK,    64'd0},
      '{8'hff,                  1'b1, 1'b1, dwexpr_pkg::ST_OK,    64'hff},
      '{dwexpr_pkg::OP_CONST1S, 1'b0, 1'b0, dwexpr_pkg::ST_OK,    64'd0},
      '{8'h80,                  1'b1, 1'b1, dwexpr_pkg::ST_OK,    64'hffff_ffff_ffff_ff80},
      '{dwexpr_pkg::OP_CONST2U, 1'b1, 1'b1, dwexpr_pkg::ST_TRUNC, 64'd0},
      '{dwexpr_pkg::OP_CONSTS,  1'b0, 1'b0, dwexpr_pkg::ST_OK,    64'd0},
      '{8'h7f,                  1'b1, 1'b1, dwexpr_pkg::ST_OK,    64'hffff_ffff_ffff_ffff},
      '{dwexpr_pkg::OP_CONSTU,  1'b0, 1'b0, dwexpr_pkg::ST_OK,    64'd0},
      '{8'h80,                  1'b1, 1'b1, dwexpr_pkg::ST_TRUNC, 64'd0},
      '{8'hff,                  1'b0, 1'b0, dwexpr_pkg::ST_OK,    64'd0},
      '{dwexpr_pkg::OP_LIT0,    1'b1, 1'b1, dwexpr_pkg::ST_UNSUP, 64'd0},
      '{dwexpr_pkg::OP_LIT0,    1'b0, 1'b0, dwexpr_pkg::ST_OK,    64'd0},
      '{dwexpr_pkg::OP_LIT31,   1'b0, 1'b0, dwexpr_pkg::ST_OK,    64'd0},
      '{dwexpr_pkg::OP_MINUS,   1'b1, 1'b0, dwexpr_pkg::ST_OK,    64'd0},
      '{dwexpr_pkg::OP_LIT31,   1'b0, 1'b0, dwexpr_pkg::ST_OK,    64'd0},
      '{dwexpr_pkg::OP_DUP,     1'b0, 1'b0, dwexpr_pkg::ST_OK,    64'd0},
      '{dwexpr_pkg::OP_PLUS,    1'b1, 1'b0, dwexpr_pkg::ST_OK,    64'd0}
   };

   task automatic clear_operand();
      eval_phase = dwexpr_pkg::PH_OPCODE;
      eval_op    = 8'd0;
      eval_left  = 0;
      eval_accum = 64'd0;
      eval_shift = 0;
   endtask

   task automatic push_entry(input logic [63:0] v);
      if (eval_depth >= STACK_DEPTH) begin
         eval_error = dwexpr_pkg::ST_OVER;
      end else begin
         eval_stack[eval_depth] = v;
         eval_depth++;
      end
   endtask

   task automatic begin_fixed(input logic [7:0] op, input int unsigned n);
      eval_op    = op;
      eval_left  = n;
      eval_accum = 64'd0;
      eval_shift = 0;
      eval_phase = dwexpr_pkg::PH_FIXED;
   endtask

   task automatic evaluate_byte(input logic [7:0] b, input logic l,
                                output bit has_result, output outcome_type res);
      logic [63:0] top;
      logic [63:0] below;
      logic [63:0] v;
      logic [63:0] m;
      has_result = 1'b0;
      res = '{dwexpr_pkg::ST_OK, 64'd0};
      if (eval_error == dwexpr_pkg::ST_OK) begin
         case (eval_phase)
            dwexpr_pkg::PH_OPCODE: begin
               case (b)
                  dwexpr_pkg::OP_ADDR: begin_fixed(b, (addr_size == 4'd4) ? 4 : 8);
                  dwexpr_pkg::OP_CONST1U, dwexpr_pkg::OP_CONST1S: begin_fixed(b, 1);
                  dwexpr_pkg::OP_CONST2U, dwexpr_pkg::OP_CONST2S: begin_fixed(b, 2);
                  dwexpr_pkg::OP_CONST4U, dwexpr_pkg::OP_CONST4S: begin_fixed(b, 4);
                  dwexpr_pkg::OP_CONST8U, dwexpr_pkg::OP_CONST8S: begin_fixed(b, 8);
                  dwexpr_pkg::OP_CONSTU, dwexpr_pkg::OP_CONSTS: begin
                     eval_op    = b;
                     eval_accum = 64'd0;
                     eval_shift = 0;
                     eval_phase = (b == dwexpr_pkg::OP_CONSTU) ? dwexpr_pkg::PH_ULEB
                                                               : dwexpr_pkg::PH_SLEB;
                  end
                  dwexpr_pkg::OP_DUP: begin
                     if (eval_depth == 0) eval_error = dwexpr_pkg::ST_UNDER;
                     else push_entry(eval_stack[eval_depth - 1]);
                  end
                  dwexpr_pkg::OP_PLUS, dwexpr_pkg::OP_MINUS: begin
                     if (eval_depth < 2) begin
                        eval_error = dwexpr_pkg::ST_UNDER;
                     end else begin
                        top   = eval_stack[eval_depth - 1];
                        below = eval_stack[eval_depth - 2];
                        eval_depth--;
                        eval_stack[eval_depth - 1] = (b == dwexpr_pkg::OP_PLUS) ? below + top
                                                                                : below - top;
                     end
                  end
                  default: begin
                     if (b inside {[dwexpr_pkg::OP_LIT0:dwexpr_pkg::OP_LIT31]})
                        push_entry(64'(b - dwexpr_pkg::OP_LIT0));
                     else eval_error = dwexpr_pkg::ST_UNSUP;
                  end
               endcase
            end
            dwexpr_pkg::PH_FIXED: begin
               if (eval_shift < 64) eval_accum |= 64'(b) << eval_shift;
               eval_shift += 8;
               if (eval_left > 0) eval_left--;
               if (eval_left == 0) begin
                  v = eval_accum;
                  if (eval_op inside {dwexpr_pkg::OP_CONST1S, dwexpr_pkg::OP_CONST2S,
                                      dwexpr_pkg::OP_CONST4S}) begin
                     m = 64'd1 << (eval_shift - 1);
                     v = v & ((m << 1) - 64'd1);
                     v = (v ^ m) - m;
                  end
                  clear_operand();
                  push_entry(v);
               end
            end
            default: begin
               if (eval_shift < 64) begin
                  eval_accum |= 64'(b[6:0]) << eval_shift;
                  eval_shift += 7;
               end
               if (!b[7]) begin
                  v = eval_accum;
                  // sign fill only while the payload is narrower than 64 bits
                  if (eval_phase == dwexpr_pkg::PH_SLEB && eval_shift < 64 && b[6])
                     v |= ~64'd0 << eval_shift;
                  clear_operand();
                  push_entry(v);
               end
            end
         endcase
      end
      if (l) begin
         if (eval_error == dwexpr_pkg::ST_OK && eval_phase != dwexpr_pkg::PH_OPCODE)
            eval_error = dwexpr_pkg::ST_TRUNC;
         if (eval_error != dwexpr_pkg::ST_OK) res = '{eval_error, 64'd0};
         else if (eval_depth == 0) res = '{dwexpr_pkg::ST_EMPTY, 64'd0};
         else res = '{dwexpr_pkg::ST_OK, eval_stack[eval_depth - 1]};
         has_result = 1'b1;
         eval_depth = 0;
         eval_error = dwexpr_pkg::ST_OK;
         clear_operand();
      end
   endtask

   task automatic send_byte(input logic [7:0] b, input logic l, input logic typed,
                            input dwexpr_pkg::status_type ts, input logic [63:0] tv);
      bit          got;
      outcome_type res;
      if (!quiet && $urandom_range(0, 7) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= l;
      do @(posedge clock); while (!req_tready);
      sent++;
      evaluate_byte(b, l, got, res);
      if (got) begin
         if (typed) pending_results.push_back('{ts, tv});
         else pending_results.push_back(res);
      end
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_addr_size(input logic [3:0] v);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      addr_size = v;
   endtask

   function automatic logic [7:0] operand_byte();
      case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return 8'hff;
         2: return 8'h80;
         3: return 8'h7f;
         default: return 8'($urandom);
      endcase
   endfunction

   // mostly well-formed expressions, with noise bytes, misuse and cut-off tails
   task automatic send_expression();
      logic [7:0]  code [$];
      int unsigned n_ops, d, k, j, len, pick, idx, cut;
      if ($urandom_range(0, 14) == 0) begin
         n_ops = $urandom_range(16, 17);
         for (k = 0; k < n_ops; k++)
            code.push_back(dwexpr_pkg::OP_LIT0 + 8'($urandom_range(0, 31)));
      end else begin
         n_ops = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 22) : $urandom_range(1, 8);
         d = 0;
         for (k = 0; k < n_ops; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 5) begin
               code.push_back(8'($urandom));
            end else if (pick < 55 && pick >= 30) begin
               idx = $urandom_range(0, 8);
               if (idx == 0) begin
                  code.push_back(dwexpr_pkg::OP_ADDR);
                  len = (addr_size == 4'd4) ? 4 : 8;
               end else begin
                  code.push_back(dwexpr_pkg::OP_CONST1U + 8'(idx - 1));
                  len = 1 << ((idx - 1) >> 1);
               end
               for (j = 0; j < len; j++) code.push_back(operand_byte());
               d++;
            end else if (pick < 70 && pick >= 55) begin
               code.push_back($urandom_range(0, 1) ? dwexpr_pkg::OP_CONSTS
                                                   : dwexpr_pkg::OP_CONSTU);
               len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 4);
               for (j = 0; j + 1 < len; j++) code.push_back({1'b1, 7'($urandom)});
               code.push_back({1'b0, 7'($urandom)});
               d++;
            end else if (pick < 80 && pick >= 70 && (d >= 1 || $urandom_range(0, 4) == 0)) begin
               code.push_back(dwexpr_pkg::OP_DUP);
               d++;
            end else if (pick >= 80 && (d >= 2 || $urandom_range(0, 4) == 0)) begin
               code.push_back($urandom_range(0, 1) ? dwexpr_pkg::OP_PLUS
                                                   : dwexpr_pkg::OP_MINUS);
               if (d >= 2) d--;
            end else begin
               code.push_back(dwexpr_pkg::OP_LIT0 + 8'($urandom_range(0, 31)));
               d++;
            end
         end
      end
      if ($urandom_range(0, 11) == 0) begin
         cut = $urandom_range(0, code.size() - 1);
         code = code[0:cut];
      end
      for (j = 0; j < code.size(); j++)
         send_byte(code[j], j == code.size() - 1, 1'b0, dwexpr_pkg::ST_OK, 64'd0);
   endtask

   always @(posedge clock) begin
      if (quiet) begin
         rsp_tready <= 1'b1;
      end else if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 7) == 0) begin
         rsp_tready <= 1'b0;
         stall_left <= $urandom_range(0, 5);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      outcome_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected transfer: status %0d value %h", rsp_tuser, rsp_tdata);
         end else begin
            want = pending_results.pop_front();
            if (rsp_tuser !== want.status || rsp_tdata !== want.value) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected status %0d value %h, got status %0d value %h",
                           want.status, want.value, rsp_tuser, rsp_tdata);
            end
         end
      end
   end

   initial begin
      logic [3:0]  settings [6] = '{4'd4, 4'd0, 4'd15, 4'd8, 4'd5, 4'd4};
      int unsigned p, r, target;
      eval_depth = 0;
      eval_error = dwexpr_pkg::ST_OK;
      addr_size  = dwexpr_pkg::ADDR_SIZE_RESET;
      clear_operand();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (r = 0; r < N_PROBES; r++)
         send_byte(probes[r].code, probes[r].last, probes[r].typed,
                   probes[r].status, probes[r].value);
      wait_idle();
      for (p = 0; p < 6; p++) begin
         if (p == 5) quiet = 1'b1;
         write_addr_size(settings[p]);
         target = sent + 170;
         while (sent < target) send_expression();
         wait_idle();
      end
      if (mismatches == 0)
         $display("[dwarf_expression_stack_evaluator] OK");
      else
         $display("[dwarf_expression_stack_evaluator] ERROR");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("[dwarf_expression_stack_evaluator] ERROR");
      $finish;
   end

endmodule
